### sv/ttcg_pkg.sv
// Package for the tap tempo clock generator.
// Holds the counter width, the register reset value and the transaction types.
// No dependencies.
package ttcg_pkg;

   localparam int unsigned COUNT_WIDTH = 32;
   localparam int unsigned HOLD_WIDTH  = 8;
   localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 8'd10;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [HOLD_WIDTH-1:0]  hold_type;

   typedef struct packed {
      logic clock_in_level;
      logic tap_pressed;
      logic mode_throw_down;
      logic mode_throw_up;
   } req_type;

   typedef struct packed {
      logic clock_out;
      logic clock_in_led;
   } rsp_type;

endpackage

### sv/tap_tempo_clock_generator.sv
// Tap tempo clock generator top level: input register, core, result register, csr.
// A request is held in the input register, then its result in the result register,
// which drives the response transaction.
// Throughput: one tick per cycle unless rsp_stall holds back the result.
// Reset: synchronous; clears all tick state, empties both registers, release_hold = 10.
// Depends on ttcg_pkg and ttcg_core.
module tap_tempo_clock_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ttcg_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ttcg_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  ttcg_pkg::hold_type csr_wdata
);

   logic               in_valid_ff;
   ttcg_pkg::req_type  in_data_ff;
   logic               out_valid_ff;
   ttcg_pkg::rsp_type  out_data_ff;
   ttcg_pkg::hold_type hold_ff;
   ttcg_pkg::rsp_type  step_result;
   logic               advance;
   logic               load_in;
   logic               step_en;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign load_in   = !in_valid_ff || advance;
   assign step_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   ttcg_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .item         (in_data_ff),
      .release_hold (hold_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hold_ff      <= ttcg_pkg::HOLD_RESET;
      end else begin
         if (load_in) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            hold_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= step_result;
      end
   end

endmodule

### sv/ttcg_core.sv
// Tick processing core: tick counter, tap timing state, edge flags and output levels.
// Computes one tick's result from registered state and updates the state on step_en.
// Depends on ttcg_pkg.
module ttcg_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  ttcg_pkg::req_type  item,
   input  ttcg_pkg::hold_type release_hold,
   output ttcg_pkg::rsp_type  result
);

   ttcg_pkg::count_type tick_ff, tick_in;
   ttcg_pkg::count_type last_tap_ff, last_tap_in;
   ttcg_pkg::count_type period_ff, period_in;
   ttcg_pkg::count_type cycle_start_ff, cycle_start_in;
   ttcg_pkg::count_type tap_seen_ff, tap_seen_in;
   logic clk_up_ff, clk_up_in;
   logic clk_down_ff, clk_down_in;
   logic clk_struck_ff, clk_struck_in;
   logic tp_up_ff, tp_up_in;
   logic tp_down_ff, tp_down_in;
   logic out_clock_ff, out_clock_in;
   logic out_led_ff, out_led_in;

   ttcg_pkg::count_type new_period;
   ttcg_pkg::count_type hold_diff;
   ttcg_pkg::count_type half_mark;
   ttcg_pkg::count_type full_mark;
   logic centre;
   logic fresh_centre;
   logic half_hit;
   logic full_hit;

   assign centre     = !item.mode_throw_down && !item.mode_throw_up;
   assign new_period = tick_ff - last_tap_ff;
   assign hold_diff  = tick_ff - tap_seen_ff;
   assign half_mark  = cycle_start_ff + (period_ff >> 1);
   assign full_mark  = cycle_start_ff + period_ff;

   always_comb begin
      tick_in        = tick_ff + ttcg_pkg::count_type'(1);
      last_tap_in    = last_tap_ff;
      period_in      = period_ff;
      cycle_start_in = cycle_start_ff;
      tap_seen_in    = tap_seen_ff;
      clk_up_in      = clk_up_ff;
      clk_down_in    = clk_down_ff;
      clk_struck_in  = clk_struck_ff;
      tp_up_in       = tp_up_ff;
      tp_down_in     = tp_down_ff;
      out_clock_in   = out_clock_ff;
      out_led_in     = out_led_ff;
      fresh_centre   = 1'b0;

      if (item.clock_in_level) begin
         if (!clk_up_ff) begin
            clk_up_in     = 1'b1;
            clk_struck_in = 1'b1;
            clk_down_in   = 1'b0;
            out_led_in    = 1'b1;
         end
      end else if (!clk_down_ff) begin
         clk_up_in   = 1'b0;
         clk_down_in = 1'b1;
         out_led_in  = 1'b0;
      end

      if (item.tap_pressed || clk_struck_in) begin
         clk_struck_in = 1'b0;
         tap_seen_in   = tick_ff;
         if (!tp_up_ff) begin
            tp_up_in   = 1'b1;
            tp_down_in = 1'b0;
            if (centre) begin
               period_in      = new_period;
               last_tap_in    = tick_ff;
               cycle_start_in = tick_ff;
               fresh_centre   = 1'b1;
            end
            out_clock_in = 1'b1;
         end
      end else if (hold_diff > ttcg_pkg::count_type'(release_hold)) begin
         if (!tp_down_ff) begin
            tp_down_in   = 1'b1;
            tp_up_in     = 1'b0;
            out_clock_in = 1'b0;
         end
      end

      // cycle restarted at now: marks reduce to tests on the new period
      if (fresh_centre) begin
         half_hit = (new_period >> 1) == '0;
         full_hit = new_period == '0;
      end else begin
         half_hit = tick_ff == half_mark;
         full_hit = tick_ff == full_mark;
      end

      if (half_hit && !item.mode_throw_down) begin
         out_clock_in = 1'b0;
      end
      if (full_hit) begin
         cycle_start_in = tick_ff;
         if (!item.mode_throw_down) begin
            out_clock_in = 1'b1;
         end
      end
   end

   assign result.clock_out    = out_clock_in;
   assign result.clock_in_led = out_led_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         last_tap_ff    <= '0;
         period_ff      <= '0;
         cycle_start_ff <= '0;
         tap_seen_ff    <= '0;
         clk_up_ff      <= 1'b0;
         clk_down_ff    <= 1'b0;
         clk_struck_ff  <= 1'b0;
         tp_up_ff       <= 1'b0;
         tp_down_ff     <= 1'b0;
         out_clock_ff   <= 1'b0;
         out_led_ff     <= 1'b0;
      end else if (step_en) begin
         tick_ff        <= tick_in;
         last_tap_ff    <= last_tap_in;
         period_ff      <= period_in;
         cycle_start_ff <= cycle_start_in;
         tap_seen_ff    <= tap_seen_in;
         clk_up_ff      <= clk_up_in;
         clk_down_ff    <= clk_down_in;
         clk_struck_ff  <= clk_struck_in;
         tp_up_ff       <= tp_up_in;
         tp_down_ff     <= tp_down_in;
         out_clock_ff   <= out_clock_in;
         out_led_ff     <= out_led_in;
      end
   end

endmodule
